// ===== rtl/core/round_robin_ready_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// Round-robin ready queue - assertion macros
// Shared macros for the concurrent checks on the ready queue ports.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_READY_QUEUE_CORE_DEFINES_SVH
`define ROUND_ROBIN_READY_QUEUE_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RRQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define RRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rrq_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin ready queue - package
// Operation and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package rrq_pkg;

	// Parameter defaults
	localparam int CAPACITY_DEF = 16;
	localparam int ID_BITS_DEF  = 16;

	// Fixed field widths
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_NEXT    = 2'd1;
	localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ===== rtl/core/round_robin_ready_queue_core.sv =====
// ----------------------------------------------------------------------------
// Round-robin ready queue core
// Circular ready queue of process ids kept as a doubly linked list in slots.
// ----------------------------------------------------------------------------
// One item enters per cycle while no reply waits on the sink. An input
// register holds the item, one pass of link-update logic (free-slot encoder,
// one pointer lookup, a few slot writes) decides the new queue state, and a
// result register holds the reply until the sink takes it. Op insert adds an
// id at the tail of the round-robin order (full queue: status full), next
// makes the next-to-run id current, extract removes the current id. Every
// result also carries the current id and the entry count.
// ----------------------------------------------------------------------------
module round_robin_ready_queue_core #(
	parameter int CAPACITY = rrq_pkg::CAPACITY_DEF,
	parameter int ID_BITS  = rrq_pkg::ID_BITS_DEF,
	localparam int IN_W    = ((rrq_pkg::OP_W + ID_BITS + 7) / 8) * 8,
	localparam int OUT_W   = ((rrq_pkg::STATUS_W + 2 * ID_BITS + 1 + rrq_pkg::COUNT_W + 7)
		/ 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // op, proc_id
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata    // status, id_out, current_valid, current_id,
	                                         // entry_count
);

	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int OUT_BITS = rrq_pkg::STATUS_W + 2 * ID_BITS + 1 + rrq_pkg::COUNT_W;

	// Input stage
	logic                    valid_s1;
	logic [rrq_pkg::OP_W-1:0] op_s1;
	logic [ID_BITS-1:0]      pid_s1;

	// Slot store
	logic [ID_BITS-1:0] slot_id_q   [CAPACITY];
	logic [SLOT_W-1:0]  slot_next_q [CAPACITY];
	logic [SLOT_W-1:0]  slot_prev_q [CAPACITY];
	logic [CAPACITY-1:0] next_ok_q;
	logic [CAPACITY-1:0] prev_ok_q;
	logic [CAPACITY-1:0] used_q;

	// Queue pointers
	logic [SLOT_W-1:0]  head_q, cur_q, up_q;
	logic               cur_ok_q;
	logic [ID_BITS-1:0] cur_id_q;
	logic [CNT_W-1:0]   held_q;

	// Result register
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	// Next-state and write ports
	logic [SLOT_W-1:0]  head_n, cur_n, up_n;
	logic               cur_ok_n;
	logic [ID_BITS-1:0] cur_id_n;
	logic [CNT_W-1:0]   held_n;
	logic [rrq_pkg::STATUS_W-1:0] status;
	logic [ID_BITS-1:0] id_out;
	logic               id_we, used_set, used_clr;
	logic [SLOT_W-1:0]  free_slot, clr_slot;
	logic               nw1_en, nw2_en, pw1_en, pw2_en;
	logic [SLOT_W-1:0]  nw1_addr, nw2_addr, pw1_addr, pw2_addr;
	logic [SLOT_W-1:0]  nw1_ptr, nw2_ptr, pw1_ptr, pw2_ptr;
	logic               nw1_ok, nw2_ok, pw1_ok, pw2_ok;
	logic               go;
	logic [CNT_W+rrq_pkg::COUNT_W-1:0] held_ext;
	logic [OUT_BITS-1:0] result;

	// Step the queue when the result register can take the reply
	assign go            = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || go;

	// Lowest free slot
	always_comb begin
		free_slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end

	// Single-pass link update
	always_comb begin
		logic [SLOT_W-1:0] a, p, c, n;
		logic              pok, nok;
		a = '0; p = '0; c = '0; n = '0; pok = 1'b0; nok = 1'b0;
		head_n   = head_q;
		cur_n    = cur_q;
		up_n     = up_q;
		cur_ok_n = cur_ok_q;
		cur_id_n = cur_id_q;
		held_n   = held_q;
		status   = rrq_pkg::ST_OK;
		id_out   = '0;
		id_we    = 1'b0;
		used_set = 1'b0;
		used_clr = 1'b0;
		clr_slot = cur_q;
		nw1_en = 1'b0; nw1_addr = free_slot; nw1_ptr = '0; nw1_ok = 1'b0;
		nw2_en = 1'b0; nw2_addr = '0;        nw2_ptr = '0; nw2_ok = 1'b0;
		pw1_en = 1'b0; pw1_addr = free_slot; pw1_ptr = '0; pw1_ok = 1'b0;
		pw2_en = 1'b0; pw2_addr = '0;        pw2_ptr = '0; pw2_ok = 1'b0;
		case (op_s1)
			rrq_pkg::OP_INSERT: begin
				if (held_q == CNT_W'(CAPACITY)) begin
					status = rrq_pkg::ST_FULL;
				end else begin
					id_we    = 1'b1;
					used_set = 1'b1;
					held_n   = held_q + 1'b1;
					nw1_en   = 1'b1;
					pw1_en   = 1'b1;
					if (held_q == '0) begin
						// first entry: no links, becomes head and next to run
						head_n = free_slot;
						up_n   = free_slot;
					end else begin
						// link in just before the anchor entry
						a       = cur_ok_q ? cur_q : up_q;
						p       = slot_prev_q[a];
						pok     = prev_ok_q[a];
						nw1_ptr = a;
						nw1_ok  = 1'b1;
						pw1_ptr = p;
						pw1_ok  = pok;
						if (pok) begin
							nw2_en   = 1'b1;
							nw2_addr = p;
							nw2_ptr  = free_slot;
							nw2_ok   = 1'b1;
						end else begin
							head_n = free_slot;
						end
						pw2_en   = 1'b1;
						pw2_addr = a;
						pw2_ptr  = free_slot;
						pw2_ok   = 1'b1;
					end
				end
			end
			rrq_pkg::OP_NEXT: begin
				if (held_q == '0) begin
					status   = rrq_pkg::ST_EMPTY;
					cur_ok_n = 1'b0;
					cur_n    = '0;
					cur_id_n = '0;
				end else begin
					// make next to run current, advance with wrap to head
					c        = up_q;
					cur_n    = c;
					cur_ok_n = 1'b1;
					up_n     = next_ok_q[c] ? slot_next_q[c] : head_q;
					id_out   = slot_id_q[c];
					cur_id_n = slot_id_q[c];
				end
			end
			rrq_pkg::OP_EXTRACT: begin
				if (!cur_ok_q || held_q == '0) begin
					status = rrq_pkg::ST_EMPTY;
				end else begin
					// unlink the current entry
					c   = cur_q;
					n   = slot_next_q[c];
					p   = slot_prev_q[c];
					nok = next_ok_q[c];
					pok = prev_ok_q[c];
					if (nok) begin
						pw2_en   = 1'b1;
						pw2_addr = n;
						pw2_ptr  = p;
						pw2_ok   = pok;
					end
					if (pok) begin
						nw2_en   = 1'b1;
						nw2_addr = p;
						nw2_ptr  = n;
						nw2_ok   = nok;
					end else if (nok) begin
						head_n = n;
					end
					held_n = held_q - 1'b1;
					if (held_n == '0) begin
						head_n = '0;
						up_n   = '0;
					end else if (up_q == c) begin
						up_n = nok ? n : head_n;
					end
					id_out   = cur_id_q;
					used_clr = 1'b1;
					clr_slot = c;
					cur_ok_n = 1'b0;
					cur_n    = '0;
					cur_id_n = '0;
				end
			end
			default: begin
				// unused code: no change
			end
		endcase
	end

	// Pack the reply
	assign held_ext = {{rrq_pkg::COUNT_W{1'b0}}, held_n};
	assign result   = {held_ext[rrq_pkg::COUNT_W-1:0], cur_id_n, cur_ok_n, id_out, status};

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1  <= s_axis_tdata[rrq_pkg::OP_W-1:0];
			pid_s1 <= s_axis_tdata[rrq_pkg::OP_W +: ID_BITS];
		end
	end

	// Queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			cur_q     <= '0;
			up_q      <= '0;
			cur_ok_q  <= 1'b0;
			cur_id_q  <= '0;
			held_q    <= '0;
			next_ok_q <= '0;
			prev_ok_q <= '0;
			used_q    <= '0;
		end else if (go) begin
			head_q   <= head_n;
			cur_q    <= cur_n;
			up_q     <= up_n;
			cur_ok_q <= cur_ok_n;
			cur_id_q <= cur_id_n;
			held_q   <= held_n;
			for (int i = 0; i < CAPACITY; i++) begin
				if (nw1_en && nw1_addr == SLOT_W'(i)) begin
					next_ok_q[i] <= nw1_ok;
				end else if (nw2_en && nw2_addr == SLOT_W'(i)) begin
					next_ok_q[i] <= nw2_ok;
				end
				if (pw1_en && pw1_addr == SLOT_W'(i)) begin
					prev_ok_q[i] <= pw1_ok;
				end else if (pw2_en && pw2_addr == SLOT_W'(i)) begin
					prev_ok_q[i] <= pw2_ok;
				end
				if (used_set && free_slot == SLOT_W'(i)) begin
					used_q[i] <= 1'b1;
				end else if (used_clr && clr_slot == SLOT_W'(i)) begin
					used_q[i] <= 1'b0;
				end
			end
		end
	end

	// Slot payload: ids and link pointers
	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (id_we && free_slot == SLOT_W'(i)) begin
					slot_id_q[i] <= pid_s1;
				end
				if (nw1_en && nw1_addr == SLOT_W'(i)) begin
					slot_next_q[i] <= nw1_ptr;
				end else if (nw2_en && nw2_addr == SLOT_W'(i)) begin
					slot_next_q[i] <= nw2_ptr;
				end
				if (pw1_en && pw1_addr == SLOT_W'(i)) begin
					slot_prev_q[i] <= pw1_ptr;
				end else if (pw2_en && pw2_addr == SLOT_W'(i)) begin
					slot_prev_q[i] <= pw2_ptr;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_data_q <= OUT_W'(result);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/rrq_checker.sv =====
// ----------------------------------------------------------------------------
// Round-robin ready queue - port checker
// Concurrent checks on the result stream, bound to the core.
// ----------------------------------------------------------------------------
`include "round_robin_ready_queue_core_defines.svh"

module rrq_checker #(
	parameter int CAPACITY = rrq_pkg::CAPACITY_DEF,
	parameter int ID_BITS  = rrq_pkg::ID_BITS_DEF,
	localparam int OUT_W   = ((rrq_pkg::STATUS_W + 2 * ID_BITS + 1 + rrq_pkg::COUNT_W + 7)
		/ 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata    // status, id_out, current_valid, current_id,
	                                        // entry_count
);

	localparam int ST_LSB  = 0;
	localparam int ID_LSB  = rrq_pkg::STATUS_W;
	localparam int CV_BIT  = ID_LSB + ID_BITS;
	localparam int CID_LSB = CV_BIT + 1;
	localparam int CNT_LSB = CID_LSB + ID_BITS;
	localparam int CNT_W   = rrq_pkg::COUNT_W;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	logic [rrq_pkg::STATUS_W-1:0] status;
	logic [ID_BITS-1:0]           id_out, cur_id;
	logic                         cur_valid;
	logic [CNT_W-1:0]             count;
	logic                         res_vld;
	logic [OUT_W-1:0]             res_data;
	logic                         res_stall, no_cur, failed, full_rep, in_stall;

	assign status    = m_axis_tdata[ST_LSB +: rrq_pkg::STATUS_W];
	assign id_out    = m_axis_tdata[ID_LSB +: ID_BITS];
	assign cur_valid = m_axis_tdata[CV_BIT];
	assign cur_id    = m_axis_tdata[CID_LSB +: ID_BITS];
	assign count     = m_axis_tdata[CNT_LSB +: CNT_W];
	assign res_vld   = m_axis_tvalid;
	assign res_data  = m_axis_tdata;
	assign res_stall = m_axis_tvalid && !m_axis_tready;
	assign no_cur    = m_axis_tvalid && !cur_valid;
	assign failed    = m_axis_tvalid && status != rrq_pkg::ST_OK;
	assign full_rep  = m_axis_tvalid && status == rrq_pkg::ST_FULL;
	assign in_stall  = !s_axis_tready;

	// A stalled result stays put
	`RRQ_ASSERT_NEXT(a_hold, clk, arst_n, res_stall, res_vld && $stable(res_data), "item changed")

	// No current entry reads as id zero
	`RRQ_ASSERT_NOW(a_cur_zero, clk, arst_n, no_cur, cur_id == '0, "id without current entry")

	// A failed operation returns no id
	`RRQ_ASSERT_NOW(a_fail_id, clk, arst_n, failed, id_out == '0, "failed item returned an id")

	// Full is only reported at capacity
	`RRQ_ASSERT_NOW(a_full_cnt, clk, arst_n, full_rep, count == FULL_CNT, "full below capacity")

	// The input only stalls behind a waiting result
	`RRQ_ASSERT_NOW(a_in_stall, clk, arst_n, in_stall, res_stall, "input stalled needlessly")

endmodule

bind round_robin_ready_queue_core rrq_checker #(
	.CAPACITY(CAPACITY),
	.ID_BITS (ID_BITS)
) u_rrq_checker (.*);
